[design/slfp_pkg.sv]
// slfp_pkg: shared types and constants of the staggered led fade controller
// no dependencies; imported by every module of the block
package slfp_pkg;

    localparam int LVL_W       = 7;   // brightness level
    localparam int TAB_W       = 24;  // fade and stair table entries
    localparam int CFG_W       = 24;  // widest configuration register
    localparam int CFG_IDX_W   = 2;
    localparam int IDX_W       = 7;   // entry index of a load word
    localparam int LED_W       = 13;  // pin field of a result word
    localparam int STAIR_DEPTH = 16;
    localparam int STAIR_AW    = 4;
    localparam int MAX_LVL_RST = 100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS  = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_START      = 2'd1,
        OP_LOAD_FADE  = 2'd2,
        OP_LOAD_STAIR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_GAP  = 2'd2,
        PH_OFF  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EVAL = 2'd1,
        ST_PUSH = 2'd2
    } t_state;

    typedef struct packed {
        logic [1:0]       op;
        logic             direction;
        logic [IDX_W-1:0] entry_index;
        logic [TAB_W-1:0] entry_value;
    } t_in_word;

    typedef struct packed {
        logic [LED_W-1:0] led_pins;
        logic [1:0]       phase;
        logic             done_res;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic accept;    // input word taken this edge
        logic issue;     // table read for channel on the index port
        logic compare;   // compare and step for the channel read last cycle
        logic load_out;  // capture result word
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_eval; // accepted word starts a channel sweep
    } t_dp_sts;

endpackage

[design/slfp_ctrl.sv]
// slfp_ctrl: sequencer of the led fade controller, one word at a time
// depends on slfp_pkg
module slfp_ctrl
    import slfp_pkg::*;
#(
    parameter int CHANNELS = 13
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] o_ch
);

    localparam int CHW   = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                // nothing is taken while reset is held
                o_in_ready   = i_rst_n;
                o_cmd.accept = i_in_valid && i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    n_cnt   = '0;
                    n_state = i_sts.need_eval ? ST_EVAL : ST_PUSH;
                end
            end
            ST_EVAL: begin
                // read for channel cnt, compare for channel cnt-1
                o_cmd.issue   = (r_cnt < CNT_W'(CHANNELS));
                o_cmd.compare = (r_cnt != '0);
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CHANNELS)) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ch        = CHW'(r_cnt);
    assign o_out_valid = r_out_valid;

endmodule

[design/slfp_dp.sv]
// slfp_dp: levels, pwm pins, phase timer, fade and stair tables, result register
// depends on slfp_pkg; driven by slfp_ctrl
module slfp_dp
    import slfp_pkg::*;
#(
    parameter int CHANNELS    = 13,
    parameter int PWM_PERIOD  = 100,
    parameter int LEVEL_DEPTH = 128,
    parameter int TIME_BITS   = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_in_word             i_in,
    input  t_dp_cmd              i_cmd,
    input  logic [(CHANNELS > 1 ? $clog2(CHANNELS) : 1)-1:0] i_ch,
    output t_dp_sts              o_sts,
    output t_out_word            o_out
);

    localparam int CHW  = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
    localparam int PW   = $clog2(PWM_PERIOD);
    localparam int FAW  = $clog2(LEVEL_DEPTH);
    localparam int SUMW = TAB_W + 1;
    localparam int CW   = (TIME_BITS > SUMW) ? TIME_BITS : SUMW;

    // configuration
    logic [LVL_W-1:0] r_max_level;
    logic [CFG_W-1:0] r_fade_ticks, r_gap_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_level  <= LVL_W'(MAX_LVL_RST);
            r_fade_ticks <= '0;
            r_gap_ticks  <= '0;
        end else if (i_cfg_wr) begin
            case (i_cfg_idx)
                CFG_MAX_LEVEL:  r_max_level  <= i_cfg_data[LVL_W-1:0];
                CFG_FADE_TICKS: r_fade_ticks <= i_cfg_data;
                CFG_GAP_TICKS:  r_gap_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    logic [LVL_W-1:0]     r_level [CHANNELS];
    logic [CHANNELS-1:0]  r_pins, n_pins;
    logic [PW-1:0]        r_pwm, n_pwm;
    logic [TIME_BITS-1:0] r_timer, n_timer, timer_inc;
    t_phase               r_phase, n_phase;
    logic                 r_dir, n_dir;
    logic                 r_eval_up, r_done, n_done, clr_lvl, eval;

    // sweep pipeline
    logic [TAB_W-1:0] r_fade_mem [LEVEL_DEPTH];
    logic [TAB_W-1:0] r_stair_mem [STAIR_DEPTH];
    logic [TAB_W-1:0] r_fade_q, r_stair_q;
    logic [LVL_W-1:0] r_lvl_p, lvl_i, fidx_raw;
    logic [CHW-1:0]   r_cmp_ch;
    logic [FAW-1:0]   fidx;
    logic [STAIR_AW-1:0] sidx;
    logic [SUMW-1:0]  due;
    logic             step_ok, hit;
    t_out_word        r_out;

    assign timer_inc = (r_timer == '1) ? r_timer : r_timer + 1'b1;

    // work done on the edge that takes a word
    always_comb begin
        n_pins  = r_pins;
        n_pwm   = r_pwm;
        n_timer = r_timer;
        n_phase = r_phase;
        n_dir   = r_dir;
        n_done  = 1'b0;
        clr_lvl = 1'b0;
        eval    = 1'b0;
        case (t_op'(i_in.op))
            OP_TICK: begin
                for (int c = 0; c < CHANNELS; c++) begin
                    if (r_pwm == '0) begin
                        n_pins[c] = (r_level[c] != '0);
                    end else if (r_level[c] == LVL_W'(r_pwm)) begin
                        n_pins[c] = 1'b0;
                    end
                end
                n_pwm   = (r_pwm == PW'(PWM_PERIOD - 1)) ? '0 : r_pwm + 1'b1;
                n_timer = timer_inc;
                case (r_phase)
                    PH_ON: begin
                        if (CW'(timer_inc) > CW'(r_fade_ticks)) begin
                            n_timer = '0;
                            if (r_gap_ticks == '0) begin
                                n_phase = PH_OFF;
                                eval    = 1'b1;
                            end else begin
                                n_phase = PH_GAP;
                            end
                        end else begin
                            eval = 1'b1;
                        end
                    end
                    PH_GAP: begin
                        if (CW'(timer_inc) >= CW'(r_gap_ticks)) begin
                            n_timer = '0;
                            n_phase = PH_OFF;
                            eval    = 1'b1;
                        end
                    end
                    PH_OFF: begin
                        if (CW'(timer_inc) > CW'(r_fade_ticks)) begin
                            clr_lvl = 1'b1;
                            n_pins  = '0;
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end else begin
                            eval = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_START: begin
                if (r_phase == PH_IDLE) begin
                    n_dir   = i_in.direction;
                    n_phase = PH_ON;
                    n_timer = '0;
                    eval    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_sts.need_eval = eval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins    <= '0;
            r_pwm     <= '0;
            r_timer   <= '0;
            r_phase   <= PH_IDLE;
            r_dir     <= 1'b0;
            r_eval_up <= 1'b0;
            r_done    <= 1'b0;
        end else if (i_cmd.accept) begin
            r_pins    <= n_pins;
            r_pwm     <= n_pwm;
            r_timer   <= n_timer;
            r_phase   <= n_phase;
            r_dir     <= n_dir;
            r_eval_up <= (n_phase == PH_ON);
            r_done    <= n_done;
        end
    end

    // issue side: table addresses for one channel
    assign lvl_i    = r_level[i_ch];
    assign fidx_raw = r_eval_up ? lvl_i : LVL_W'(r_max_level - lvl_i);
    assign fidx     = ({1'b0, fidx_raw} >= (LVL_W+1)'(LEVEL_DEPTH)) ?
                      FAW'(LEVEL_DEPTH - 1) : FAW'(fidx_raw);
    assign sidx     = r_dir ? STAIR_AW'(CHANNELS - 1) - STAIR_AW'(i_ch) : STAIR_AW'(i_ch);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_phase == PH_IDLE) begin
            if (t_op'(i_in.op) == OP_LOAD_FADE &&
                    {1'b0, i_in.entry_index} < (IDX_W+1)'(LEVEL_DEPTH)) begin
                r_fade_mem[FAW'(i_in.entry_index)] <= i_in.entry_value;
            end
            if (t_op'(i_in.op) == OP_LOAD_STAIR &&
                    i_in.entry_index[IDX_W-1:STAIR_AW] == '0) begin
                r_stair_mem[i_in.entry_index[STAIR_AW-1:0]] <= i_in.entry_value;
            end
        end
        if (i_cmd.issue) begin
            r_fade_q  <= r_fade_mem[fidx];
            r_stair_q <= r_stair_mem[sidx];
            r_lvl_p   <= lvl_i;
            r_cmp_ch  <= i_ch;
        end
    end

    // compare side: one step of one channel
    assign due     = SUMW'(r_fade_q) + SUMW'(r_stair_q);
    assign step_ok = r_eval_up ? (r_lvl_p < r_max_level) : (r_lvl_p != '0);
    assign hit     = step_ok && (CW'(r_timer) >= CW'(due));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_level[c] <= '0;
            end
        end else if (i_cmd.accept && clr_lvl) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_level[c] <= '0;
            end
        end else if (i_cmd.compare && hit) begin
            r_level[r_cmp_ch] <= r_eval_up ? r_lvl_p + 1'b1 : r_lvl_p - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.led_pins <= LED_W'(r_pins);
            r_out.phase    <= r_phase;
            r_out.done_res <= r_done;
        end
    end

    assign o_out = r_out;

endmodule

[design/staggered_led_fade_pwm.sv]
// staggered_led_fade_pwm: top level of the staggered led fade controller
// depends on slfp_pkg, slfp_ctrl and slfp_dp
//
//  channel  | handshake               | word
//  ---------+-------------------------+-----------------------------------------------
//  input    | i_in_valid / o_in_ready | t_in_word: op, direction, entry_index/value
//  result   | o_out_valid/i_out_ready | t_out_word: led_pins, phase, done_res
//  config   | i_cfg_wr (no wait)      | i_cfg_idx, i_cfg_data
//
// a tick or start word that runs a fade sweep goes through accept, one fade table
// read per channel through the single read port with the compare for each channel
// in the cycle after its read, then the result capture
// any other word goes through accept and result capture
// one word is in flight at a time; a new word is taken while the previous
// result still waits in the output register, and a full output register stalls
// the capture of the next result
// reset is synchronous and active low; tables are not cleared and hold nothing
// meaningful until loaded
module staggered_led_fade_pwm
    import slfp_pkg::*;
#(
    parameter int CHANNELS    = 13,
    parameter int PWM_PERIOD  = 100,
    parameter int LEVEL_DEPTH = 128,
    parameter int TIME_BITS   = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out
);

    localparam int CHW = CHANNELS > 1 ? $clog2(CHANNELS) : 1;

    t_dp_cmd        cmd;   // sequencer strobes
    t_dp_sts        sts;   // sweep request from the accept-cycle logic
    logic [CHW-1:0] ch;    // channel under read in the sweep

    // state machine: accept, sweep over channels, result capture
    slfp_ctrl #(
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_ch        (ch)
    );

    // pwm, phase timer, levels, tables and the result register
    slfp_dp #(
        .CHANNELS    (CHANNELS),
        .PWM_PERIOD  (PWM_PERIOD),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (i_cfg_wr),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .i_ch       (ch),
        .o_sts      (sts),
        .o_out      (o_out)
    );

endmodule

[design/slfp_chk.sv]
// slfp_chk: port-level checks of the staggered led fade controller, bound to the top
// depends on slfp_pkg and staggered_led_fade_pwm
module slfp_chk
    import slfp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out
);

    // a finished sequence shows idle with all pins low
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.done_res |-> o_out.phase == PH_IDLE && o_out.led_pins == '0)
        else $error("done word with pins or phase not cleared");

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");

    // one word in flight
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second word taken while one is in flight");

    // a new result only follows a word in flight
    a_result_after_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared with no word in flight");

endmodule

bind staggered_led_fade_pwm slfp_chk u_slfp_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

[bench/testbench.sv]
// testbench: self-checking bench for the staggered led fade controller
// drives ticks, starts and table loads, predicts every result word in a tracker class
// depends on slfp_pkg and staggered_led_fade_pwm
module testbench;
    import slfp_pkg::*;

    localparam int N_CH       = 13;
    localparam int PWM_PERIOD = 100;
    localparam int FADE_DEPTH = 128;
    localparam logic [TAB_W-1:0] TIMER_MAX = '1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_TARGET = 1010;   // directed words, fill and sessions; the endless run adds the rest

    // tracker of the controller state, fed with every accepted input word
    class led_fade_tracker;
        bit [LVL_W-1:0] cfg_max_level;
        bit [CFG_W-1:0] cfg_fade_ticks;
        bit [CFG_W-1:0] cfg_gap_ticks;
        bit [LVL_W-1:0] levels [N_CH];
        int             pwm_cnt;
        bit [TAB_W-1:0] timer;
        t_phase         phase;
        bit             dir;
        bit [LED_W-1:0] pins;
        bit [TAB_W-1:0] fade_tab [FADE_DEPTH];
        bit [TAB_W-1:0] stair_tab [STAIR_DEPTH];
        t_out_word      pending_pin_states [$];
        int             errors;
        int             checked;

        function new();
            cfg_max_level  = MAX_LVL_RST;
            cfg_fade_ticks = 0;
            cfg_gap_ticks  = 0;
            foreach (levels[i]) levels[i] = 0;
            pwm_cnt = 0;
            timer   = 0;
            phase   = PH_IDLE;
            dir     = 0;
            pins    = 0;
            errors  = 0;
            checked = 0;
        endfunction

        function int pending();
            return pending_pin_states.size();
        endfunction

        // one sweep over all channels; each steps at most once
        function void sweep_levels(bit rising);
            int             ch;
            int             stair;
            bit [LVL_W-1:0] lvl;
            bit [LVL_W-1:0] tab_idx;
            bit [TAB_W:0]   due;
            for (ch = 0; ch < N_CH; ch++) begin
                stair = dir ? (N_CH - 1 - ch) : ch;
                lvl   = levels[ch];
                if (rising) begin
                    if (lvl >= cfg_max_level)
                        continue;
                    tab_idx = lvl;
                end else begin
                    if (lvl == 0)
                        continue;
                    tab_idx = cfg_max_level - lvl;   // wraps at 7 bits
                end
                due = {1'b0, fade_tab[tab_idx]} + {1'b0, stair_tab[stair]};
                if ({1'b0, timer} >= due)
                    levels[ch] = rising ? lvl + 1'b1 : lvl - 1'b1;
            end
        endfunction

        function void begin_fade_off();
            phase = PH_OFF;
            timer = 0;
            sweep_levels(1'b0);
        endfunction

        function void note_word(t_in_word w);
            int        ch;
            bit        done;
            t_out_word e;
            done = 0;
            case (w.op)
                OP_TICK: begin
                    for (ch = 0; ch < N_CH; ch++) begin
                        if (pwm_cnt == 0)
                            pins[ch] = (levels[ch] != 0);
                        else if (levels[ch] == pwm_cnt)
                            pins[ch] = 1'b0;
                    end
                    pwm_cnt = (pwm_cnt + 1 >= PWM_PERIOD) ? 0 : pwm_cnt + 1;
                    if (timer != TIMER_MAX)
                        timer++;
                    case (phase)
                        PH_ON: begin
                            if (timer > cfg_fade_ticks) begin
                                phase = PH_GAP;
                                timer = 0;
                                if (cfg_gap_ticks == 0)
                                    begin_fade_off();
                            end else begin
                                sweep_levels(1'b1);
                            end
                        end
                        PH_GAP: begin
                            if (timer >= cfg_gap_ticks)
                                begin_fade_off();
                        end
                        PH_OFF: begin
                            if (timer > cfg_fade_ticks) begin
                                foreach (levels[i]) levels[i] = 0;
                                pins  = 0;
                                phase = PH_IDLE;
                                done  = 1;
                            end else begin
                                sweep_levels(1'b0);
                            end
                        end
                        default: ;
                    endcase
                end
                OP_START: begin
                    if (phase == PH_IDLE) begin
                        dir   = w.direction;
                        phase = PH_ON;
                        timer = 0;
                        sweep_levels(1'b1);
                    end
                end
                OP_LOAD_FADE: begin
                    if (phase == PH_IDLE)
                        fade_tab[w.entry_index] = w.entry_value;
                end
                default: begin
                    if (phase == PH_IDLE && w.entry_index < STAIR_DEPTH)
                        stair_tab[w.entry_index[STAIR_AW-1:0]] = w.entry_value;
                end
            endcase
            e.led_pins = pins;
            e.phase    = phase;
            e.done_res = done;
            pending_pin_states.push_back(e);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("mismatch %s: got 0x%0h, expected 0x%0h (result %0d)",
                     what, got, want, checked);
        endtask

        task check_word(t_out_word got);
            t_out_word want;
            checked++;
            if (pending_pin_states.size() == 0) begin
                report_mismatch("unexpected result word", got, 0);
                return;
            end
            want = pending_pin_states.pop_front();
            if (got.led_pins !== want.led_pins)
                report_mismatch("led_pins", got.led_pins, want.led_pins);
            if (got.phase !== want.phase)
                report_mismatch("phase", got.phase, want.phase);
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", got.done_res, want.done_res);
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_word             in_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_word            out_word;

    led_fade_tracker tracker;
    int items_sent = 0;
    int burst_left = 0;
    int ramp_slope = 2;

    staggered_led_fade_pwm u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // fade table profile: roughly linear in the level so fades cover a good range
    function automatic int ramp_value(int k);
        return (k * ramp_slope) / 4 + $urandom_range(0, 1);
    endfunction

    // offer one word, hold it until taken, then maybe open a gap in the burst
    task automatic send(input t_op op, input bit dir, input int idx, input int val,
                        input bit counted);
        t_in_word w;
        int       gap;
        w.op          = op;
        w.direction   = dir;
        w.entry_index = idx[IDX_W-1:0];
        w.entry_value = val[TAB_W-1:0];
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        tracker.note_word(w);
        if (counted)
            items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 24);
            // a third of bursts run straight into the next one
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_tick();
        send(OP_TICK, $urandom_range(0, 1), $urandom_range(0, 127), $urandom, 1'b1);
    endtask

    // start or load offered while a fade runs: the block drops it
    task automatic send_ignored();
        send(t_op'($urandom_range(1, 3)), $urandom_range(0, 1), $urandom_range(0, 127),
             $urandom, 1'b0);
    endtask

    task automatic idle_load();
        bit to_fade;
        int idx;
        int val;
        to_fade = $urandom_range(0, 1);
        if (to_fade)
            idx = $urandom_range(0, FADE_DEPTH - 1);
        else
            idx = ($urandom_range(0, 3) == 0) ? $urandom_range(STAIR_DEPTH, 127)
                                              : $urandom_range(0, STAIR_DEPTH - 1);
        if ($urandom_range(0, 7) == 0)
            val = $urandom;
        else
            val = to_fade ? ramp_value(idx) : $urandom_range(0, 4);
        send(to_fade ? OP_LOAD_FADE : OP_LOAD_STAIR, $urandom_range(0, 1), idx, val,
             to_fade || idx < STAIR_DEPTH);
    endtask

    // stop offering and let every outstanding result word drain out
    task automatic pause_for_results();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_wr   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[CFG_W-1:0];
        @(posedge clk);
        case (idx)
            CFG_MAX_LEVEL:  tracker.cfg_max_level  = val[LVL_W-1:0];
            CFG_FADE_TICKS: tracker.cfg_fade_ticks = val[CFG_W-1:0];
            default:        tracker.cfg_gap_ticks  = val[CFG_W-1:0];
        endcase
    endtask

    task automatic set_regs(input int max_level, input int fade_ticks, input int gap_ticks);
        write_reg(CFG_MAX_LEVEL, max_level);
        write_reg(CFG_FADE_TICKS, fade_ticks);
        write_reg(CFG_GAP_TICKS, gap_ticks);
        cfg_wr <= 1'b0;
    endtask

    // every table entry a fade can read gets written before any real fade
    task automatic fill_tables();
        ramp_slope = $urandom_range(0, 4);
        for (int s = 0; s < STAIR_DEPTH; s++)
            send(OP_LOAD_STAIR, $urandom_range(0, 1), s, $urandom_range(0, 4), 1'b1);
        for (int k = 0; k < FADE_DEPTH; k++)
            send(OP_LOAD_FADE, $urandom_range(0, 1), k, ramp_value(k), 1'b1);
    endtask

    // start a sequence and tick it to completion, sprinkling dropped words in
    task automatic run_fade(input bit dir, input int tick_cap);
        int n;
        n = 0;
        send(OP_START, dir, $urandom_range(0, 127), $urandom, 1'b1);
        while (tracker.phase != PH_IDLE && n < tick_cap) begin
            if ($urandom_range(0, 15) == 0)
                send_ignored();
            else
                send_tick();
            n++;
        end
    endtask

    // result side: check every word taken, stall on a changing pattern
    initial begin : result_sink
        int cyc;
        int mode;
        int hold_left;
        int next_hold;
        cyc       = 0;
        mode      = 0;
        hold_left = 0;
        next_hold = 300;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                tracker.check_word(out_word);
            cyc++;
            if (cyc % 200 == 0)
                mode = $urandom_range(0, 3);
            // long hold-offs so the block backs up into its input
            if (hold_left == 0 && next_hold <= 800 && tracker.checked >= next_hold) begin
                hold_left = 400;
                next_hold += 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (cyc % 5 >= 2);
                endcase
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int r;
        int max_level;
        int fade_ticks;
        int gap_ticks;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: no brightness so no table entry takes effect yet
        set_regs(0, 1, 1);
        send_tick();
        send(OP_LOAD_FADE, 1'b0, 0, 0, 1'b1);
        send(OP_LOAD_FADE, 1'b1, 127, 24'hFFFFFF, 1'b1);
        send(OP_LOAD_STAIR, 1'b0, 15, 24'hFFFFFF, 1'b1);
        send(OP_LOAD_STAIR, 1'b1, 16, 0, 1'b1);            // beyond the stair table
        send(OP_LOAD_STAIR, 1'b1, 127, 24'hFFFFFF, 1'b1);  // likewise dropped
        send(OP_START, 1'b0, 0, 0, 1'b1);
        send_tick();
        send(OP_START, 1'b1, 127, 24'hFFFFFF, 1'b1);       // start while busy
        send_tick();
        send(OP_LOAD_FADE, 1'b0, 5, 24'hFFFFFF, 1'b1);     // load while busy
        send_tick();
        send(OP_LOAD_STAIR, 1'b0, 0, 24'hFFFFFF, 1'b1);    // load while busy
        while (tracker.phase != PH_IDLE)
            send_tick();
        // zero fade and gap: fade off follows fade on at the first tick, with no gap
        pause_for_results();
        set_regs(0, 0, 0);
        run_fade(1'b1, 100);

        pause_for_results();
        fill_tables();

        // sessions: new settings, a few idle words, then one full sequence
        while (items_sent < ITEM_TARGET) begin
            pause_for_results();
            r = $urandom_range(0, 5);
            max_level = (r == 0) ? 0 : (r == 1) ? MAX_LVL_RST : $urandom_range(1, 100);
            r = $urandom_range(0, 7);
            fade_ticks = (r == 0) ? 0 : (r == 1) ? $urandom_range(100, 130)
                                                 : $urandom_range(1, 40);
            r = $urandom_range(0, 3);
            gap_ticks = (r == 0) ? 0 : (r == 1) ? 1 : $urandom_range(2, 12);
            set_regs(max_level, fade_ticks, gap_ticks);
            if ($urandom_range(0, 9) == 0)
                fill_tables();
            repeat ($urandom_range(0, 8)) begin
                if ($urandom_range(0, 1) == 0)
                    send_tick();
                else
                    idle_load();
            end
            run_fade($urandom_range(0, 1), CYCLE_LIMIT);
        end

        // widest settings: the fade never ends, so this runs last
        pause_for_results();
        set_regs(MAX_LVL_RST, 24'hFFFFFF, 24'hFFFFFF);
        run_fade($urandom_range(0, 1), 40);

        pause_for_results();
        repeat (40) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report_mismatch("result words never delivered", 0, tracker.pending());
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
